// ===== hdl/deadline_timer_queue_macros.svh =====
// Assertion macros for the deadline timer queue.
`ifndef DEADLINE_TIMER_QUEUE_MACROS_SVH
`define DEADLINE_TIMER_QUEUE_MACROS_SVH

// Checked on every clock edge outside reset.
`define DTQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked in the cycle after the condition.
`define DTQ_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) else $error(msg);

`endif

// ===== hdl/dtq_pkg.sv =====
// Shared types and constants for the deadline timer queue.
`timescale 1ns / 1ps
package dtq_pkg;
  localparam int TIMERS    = 16;
  localparam int TIME_BITS = 48;
  localparam int CNT_BITS  = 32;
  localparam int CNT_W     = $clog2(TIMERS + 1);
  localparam int LIMIT_W   = 5;
  localparam int MAX_KIND  = 5;

  typedef enum logic [1:0] {
    CMD_SCHED  = 2'd0,
    CMD_CANCEL = 2'd1,
    CMD_STOP   = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_STOPPED   = 3'd1,
    ST_BAD_EVENT = 3'd2,
    ST_SINK_GONE = 3'd3,
    ST_LIMIT     = 3'd4,
    ST_EXHAUSTED = 3'd5,
    ST_NOT_FOUND = 3'd6,
    ST_GEN_MISM  = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    RK_REPLY   = 2'd0,
    RK_FIRED   = 2'd1,
    RK_SUMMARY = 2'd2
  } rkind_e;

  typedef enum logic [2:0] {
    OP_NOP    = 3'd0,
    OP_INSERT = 3'd1,
    OP_CANCEL = 3'd2,
    OP_POP    = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  typedef struct packed {
    logic                 valid;
    logic [CNT_BITS-1:0]  id;
    logic [CNT_BITS-1:0]  gen;
    logic [TIME_BITS-1:0] deadline;
    logic [2:0]           kind;
    logic [31:0]          tag;
    logic [15:0]          sink;
  } entry_t;

  typedef struct packed {
    op_e                 op;
    entry_t              new_ent;
    logic [CNT_BITS-1:0] cid;
    logic [CNT_BITS-1:0] cgen;
  } ctl_t;
endpackage

// ===== hdl/dtq_cell.sv =====
// One slot of the sorted timer chain.
`timescale 1ns / 1ps
module dtq_cell import dtq_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  ctl_t   ctl_i,
  input  entry_t left_i,
  input  entry_t right_i,
  input  logic   left_stay_i,
  input  logic   left_sh_i,
  output entry_t ent_o,
  output logic   stay_o,
  output logic   sh_o,
  output logic   idm_o
);
  entry_t ent_q, ent_d;
  logic   hit;

  assign idm_o  = ent_q.valid && (ent_q.id == ctl_i.cid);
  assign hit    = idm_o && (ent_q.gen == ctl_i.cgen);
  assign stay_o = ent_q.valid && (ent_q.deadline <= ctl_i.new_ent.deadline);
  assign sh_o   = left_sh_i || ((ctl_i.op == OP_CANCEL) && hit);
  assign ent_o  = ent_q;

  always_comb begin
    ent_d = ent_q;
    case (ctl_i.op)
      OP_INSERT: begin
        if (!stay_o) begin
          ent_d = left_stay_i ? ctl_i.new_ent : left_i;
        end
      end
      OP_CANCEL, OP_POP: begin
        if (sh_o) ent_d = right_i;
      end
      OP_CLEAR: ent_d.valid = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else begin
      ent_q <= ent_d;
    end
  end
endmodule

// ===== hdl/deadline_timer_queue.sv =====
// Top level: timer queue built as a sorted chain of slot cells.
//  channel | dir | handshake          | payload
//  s       | in  | s_tvalid/s_tready  | s_tdata, s_tuser = command
//  m       | out | m_tvalid/m_tready  | m_tdata, m_tuser = result_kind, m_tlast
//  cfg     | in  | cfg_we_i           | cfg_wdata_i = timer_limit
// Schedule, cancel and stop reply in the cycle after acceptance; the next transaction is
// taken only once the reply has left the output register.
// A tick latches now_time, then emits one fired result per due timer and then a summary,
// set by popping the chain head once per cycle while the output register is free.
// A full output register stalls the chain. Reset clears all slots, the seq and fired
// counters and the stop flag; timer_id and generation reset to 1, timer_limit to 16.
`timescale 1ns / 1ps
`include "deadline_timer_queue_macros.svh"
module deadline_timer_queue import dtq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid,
  output logic               s_tready,
  // deadline, event_kind, event_tag, sink_handle, sink_live, cancel_id,
  // cancel_generation, now_time
  input  logic [215:0]       s_tdata,
  // command
  input  logic [1:0]         s_tuser,
  output logic               m_tvalid,
  input  logic               m_tready,
  // status, timer_id, timer_generation, fired_kind, fired_tag, fired_sink,
  // next_due, has_next, is_stopped, fired_count
  output logic [175:0]       m_tdata,
  // result_kind
  output logic [1:0]         m_tuser,
  output logic               m_tlast,
  input  logic               cfg_we_i,
  input  logic [LIMIT_W-1:0] cfg_wdata_i
);
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_TICK = 2'b10
  } state_e;

  state_e               state_q, state_d;
  logic [LIMIT_W-1:0]   limit_q;
  logic [CNT_BITS-1:0]  id_q, id_d, gen_q, gen_d, seq_q, seq_d;
  logic                 stop_q, stop_d;
  logic [TIME_BITS-1:0] now_q, now_d;
  logic [CNT_W-1:0]     fcnt_q, fcnt_d;
  logic                 out_vld_q;
  logic [175:0]         out_data_q, out_data_d;
  logic [1:0]           out_user_q, out_user_d;
  logic                 out_last_q, out_last_d;
  logic                 out_ld;

  ctl_t                 ctl;
  entry_t               ent  [TIMERS];
  logic [TIMERS-1:0]    stay, sh, idm;
  logic [CNT_W-1:0]     cnt, lim;

  logic [TIME_BITS-1:0] in_deadline, in_now;
  logic [2:0]           in_kind;
  logic [31:0]          in_tag;
  logic [15:0]          in_sink;
  logic                 in_live;
  logic [31:0]          in_cid, in_cgen;
  logic                 in_fire, out_free, due;
  status_e              st;

  assign in_deadline = s_tdata[47:0];
  assign in_kind     = s_tdata[50:48];
  assign in_tag      = s_tdata[82:51];
  assign in_sink     = s_tdata[98:83];
  assign in_live     = s_tdata[99];
  assign in_cid      = s_tdata[131:100];
  assign in_cgen     = s_tdata[163:132];
  assign in_now      = s_tdata[211:164];

  assign s_tready = (state_q == S_IDLE) && !out_vld_q;
  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !out_vld_q || m_tready;
  assign due      = ent[0].valid && (ent[0].deadline <= now_q) && !stop_q;

  assign m_tvalid = out_vld_q;
  assign m_tdata  = out_data_q;
  assign m_tuser  = out_user_q;
  assign m_tlast  = out_last_q;

  for (genvar i = 0; i < TIMERS; i++) begin : g_cell
    dtq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .left_i      ((i == 0) ? entry_t'('0) : ent[(i == 0) ? 0 : i - 1]),
      .right_i     ((i == TIMERS - 1) ? entry_t'('0) : ent[(i == TIMERS - 1) ? i : i + 1]),
      .left_stay_i ((i == 0) ? 1'b1 : stay[(i == 0) ? 0 : i - 1]),
      .left_sh_i   ((i == 0) ? (ctl.op == OP_POP) : sh[(i == 0) ? 0 : i - 1]),
      .ent_o       (ent[i]),
      .stay_o      (stay[i]),
      .sh_o        (sh[i]),
      .idm_o       (idm[i])
    );
  end

  always_comb begin
    cnt = '0;
    for (int i = 0; i < TIMERS; i++) cnt = cnt + CNT_W'(ent[i].valid);
    if (32'(limit_q) > TIMERS) lim = CNT_W'(TIMERS);
    else lim = CNT_W'(limit_q);
  end

  always_comb begin
    if (stop_q) st = ST_STOPPED;
    else if (32'(in_kind) > MAX_KIND) st = ST_BAD_EVENT;
    else if (!in_live) st = ST_SINK_GONE;
    else if (cnt >= lim) st = ST_LIMIT;
    else if ((&id_q) || (&gen_q) || (&seq_q)) st = ST_EXHAUSTED;
    else st = ST_OK;
  end

  always_comb begin
    ctl.op                = OP_NOP;
    ctl.new_ent.valid     = 1'b1;
    ctl.new_ent.id        = id_q;
    ctl.new_ent.gen       = gen_q;
    ctl.new_ent.deadline  = in_deadline;
    ctl.new_ent.kind      = in_kind;
    ctl.new_ent.tag       = in_tag;
    ctl.new_ent.sink      = in_sink;
    ctl.cid               = in_cid;
    ctl.cgen              = in_cgen;
    state_d    = state_q;
    id_d       = id_q;
    gen_d      = gen_q;
    seq_d      = seq_q;
    stop_d     = stop_q;
    now_d      = now_q;
    fcnt_d     = fcnt_q;
    out_ld     = 1'b0;
    out_data_d = '0;
    out_user_d = RK_REPLY;
    out_last_d = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (cmd_e'(s_tuser))
            CMD_SCHED: begin
              out_ld          = 1'b1;
              out_data_d[2:0] = st;
              if (st == ST_OK) begin
                ctl.op            = OP_INSERT;
                out_data_d[34:3]  = id_q;
                out_data_d[66:35] = gen_q;
                id_d  = id_q + 1'b1;
                gen_d = gen_q + 1'b1;
                seq_d = seq_q + 1'b1;
              end
            end
            CMD_CANCEL: begin
              out_ld = 1'b1;
              if (stop_q) begin
                out_data_d[2:0] = ST_STOPPED;
              end else begin
                ctl.op = OP_CANCEL;
                if (|sh) out_data_d[2:0] = ST_OK;
                else if (|idm) out_data_d[2:0] = ST_GEN_MISM;
                else out_data_d[2:0] = ST_NOT_FOUND;
              end
            end
            CMD_STOP: begin
              out_ld = 1'b1;
              ctl.op = OP_CLEAR;
              stop_d = 1'b1;
            end
            default: begin
              state_d = S_TICK;
              now_d   = in_now;
              fcnt_d  = '0;
            end
          endcase
        end
      end
      S_TICK: begin
        if (out_free) begin
          out_ld = 1'b1;
          if (due) begin
            ctl.op              = OP_POP;
            out_user_d          = RK_FIRED;
            out_last_d          = 1'b0;
            out_data_d[34:3]    = ent[0].id;
            out_data_d[66:35]   = ent[0].gen;
            out_data_d[69:67]   = ent[0].kind;
            out_data_d[101:70]  = ent[0].tag;
            out_data_d[117:102] = ent[0].sink;
            fcnt_d              = fcnt_q + 1'b1;
          end else begin
            out_user_d          = RK_SUMMARY;
            out_data_d[165:118] = ent[0].valid ? ent[0].deadline : '0;
            out_data_d[166]     = ent[0].valid;
            out_data_d[167]     = stop_q;
            out_data_d[172:168] = 5'(fcnt_q);
            state_d             = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      limit_q   <= LIMIT_W'(16);
      id_q      <= CNT_BITS'(1);
      gen_q     <= CNT_BITS'(1);
      seq_q     <= '0;
      stop_q    <= 1'b0;
      fcnt_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      id_q    <= id_d;
      gen_q   <= gen_d;
      seq_q   <= seq_d;
      stop_q  <= stop_d;
      fcnt_q  <= fcnt_d;
      if (out_ld) out_vld_q <= 1'b1;
      else if (m_tready) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q <= now_d;
    if (out_ld) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
      out_last_q <= out_last_d;
    end
  end

  `DTQ_ASSERT(a_ready_empty, !s_tready || !m_tvalid, "input taken while a result waits")
  `DTQ_ASSERT(a_stop_empty, !stop_q || !ent[0].valid, "timer pending after stop")
  `DTQ_ASSERT(a_cnt_range, cnt <= CNT_W'(TIMERS), "pending count above slot count")
  `DTQ_ASSERT_NEXT(a_pop_head, ctl.op == OP_POP, m_tvalid && (m_tuser == RK_FIRED),
                   "pop without fired result")
endmodule
